FILE: rtl/core/htb_pkg.sv
package htb_pkg;

	localparam int MaxSymbols = 64;
	localparam int NodeCap    = 2 * MaxSymbols - 1;
	localparam int SlotW      = $clog2(MaxSymbols);
	localparam int CountW     = $clog2(MaxSymbols + 1);
	localparam int NodeW      = 7;
	localparam int SymW       = 8;
	localparam int FreqW      = 24;
	localparam int WeightW    = 30;

	typedef struct packed {
		logic [SymW-1:0]  symbol;
		logic [FreqW-1:0] frequency;
		logic             last;
	} sym_beat_t;

	typedef struct packed {
		logic [NodeW-1:0]   node_index;
		logic [NodeW-1:0]   left_index;
		logic [NodeW-1:0]   right_index;
		logic               left_is_leaf;
		logic               right_is_leaf;
		logic [SymW-1:0]    left_symbol;
		logic [SymW-1:0]    right_symbol;
		logic [WeightW-1:0] weight;
		logic               single_leaf;
		logic               overflow;
		logic               is_root;
	} merge_beat_t;

	typedef struct packed {
		logic [WeightW-1:0] w;
		logic [NodeW-1:0]   node;
	} heap_entry_t;

endpackage

FILE: rtl/core/htb_sym_if.sv
interface htb_sym_if
	import htb_pkg::*;
;
	logic      valid;
	logic      ready;
	sym_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/htb_merge_if.sv
interface htb_merge_if
	import htb_pkg::*;
;
	logic        valid;
	logic        ready;
	merge_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/huffman_tree_builder_unit.sv
// Huffman tree builder over a binary min-heap held in a single-write, dual-read memory.
// Channel symbols: one beat per leaf (symbol, frequency, last). Leaves are numbered in
// load order; beats beyond capacity are dropped and flagged as overflow in the results.
// A beat with last set starts the build; symbols is held low until the run is finished.
// Channel merges: one beat per merge, the final one marked is_root. A set of one symbol
// gives a single beat describing that leaf.
// Loading accepts one beat per cycle until the last beat. The build is run by one sequencer
// around the heap memory: a heapify sift level, an extract sift level and an insert sift
// level each take a read state, then a compare-and-write state. Each merge is two
// extractions and one insert, after a heapify of the whole heap at the start of the build.
// Results leave through an output register; when the receiver stalls, the sequencer
// waits at the point where it would load the next result, so nothing is lost.
// Reset clears the sequencer, the counts and the output valid; the memories are not
// cleared, as a build reads only entries written during the same set.
module huffman_tree_builder_unit
	import htb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	htb_sym_if.sink     symbols,
	htb_merge_if.source merges
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SGL   = 4'd1;
	localparam logic [3:0] S_HRD   = 4'd2;
	localparam logic [3:0] S_HLD   = 4'd3;
	localparam logic [3:0] S_SDRD  = 4'd4;
	localparam logic [3:0] S_SDCMP = 4'd5;
	localparam logic [3:0] S_TRD   = 4'd6;
	localparam logic [3:0] S_TLD   = 4'd7;
	localparam logic [3:0] S_MG    = 4'd8;
	localparam logic [3:0] S_URD   = 4'd9;
	localparam logic [3:0] S_UCMP  = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	localparam logic [1:0] RET_HEAP  = 2'd0;
	localparam logic [1:0] RET_TAKE1 = 2'd1;
	localparam logic [1:0] RET_TAKE2 = 2'd2;

	logic [3:0]          state_q;
	logic [1:0]          ret_q;
	logic [CountW-1:0]   cnt_q;
	logic [CountW-1:0]   hc_q;
	logic [NodeW-1:0]    nxt_q;
	logic [NodeW-1:0]    nn_q;
	logic                drop_q;
	logic [SlotW-1:0]    s_q;
	logic [SlotW-1:0]    pos_q;
	logic [SlotW-1:0]    i_q;
	logic [WeightW-1:0]  w_q;
	heap_entry_t         cur_q;
	heap_entry_t         a_q;
	heap_entry_t         b_q;
	logic                ov_q;
	merge_beat_t         out_q;

	heap_entry_t         heap_mem [MaxSymbols];
	logic [SymW-1:0]     sym_mem [MaxSymbols];
	heap_entry_t         hrd0_q;
	heap_entry_t         hrd1_q;
	logic [SymW-1:0]     srd0_q;
	logic [SymW-1:0]     srd1_q;

	logic                h_we;
	logic [SlotW-1:0]    h_wa;
	heap_entry_t         h_wd;
	logic [SlotW-1:0]    h_ra0;
	logic [SlotW-1:0]    h_ra1;

	logic                acc;
	logic                room;
	logic [CountW-1:0]   cnt_new;
	logic [SlotW+1:0]    lc;
	logic [SlotW+1:0]    rc;
	logic                lv;
	logic                rv;
	logic                take_l;
	logic                take_r;
	logic [WeightW-1:0]  tw;
	logic [SlotW-1:0]    parent;
	logic                out_free;
	logic                out_load;
	logic                a_leaf;
	logic                b_leaf;

	assign acc      = symbols.valid && symbols.ready;
	assign room     = cnt_q < CountW'(MaxSymbols);
	assign cnt_new  = room ? cnt_q + 1'b1 : cnt_q;
	assign lc       = {1'b0, pos_q, 1'b1};
	assign rc       = lc + 1'b1;
	assign lv       = lc < (SlotW + 2)'(hc_q);
	assign rv       = rc < (SlotW + 2)'(hc_q);
	assign take_l   = lv && (hrd0_q.w < cur_q.w);
	assign tw       = take_l ? hrd0_q.w : cur_q.w;
	assign take_r   = rv && (hrd1_q.w < tw);
	assign parent   = (i_q - 1'b1) >> 1;
	assign out_free = !ov_q || merges.ready;
	assign out_load = ((state_q == S_SGL) || (state_q == S_EMIT)) && out_free;
	assign a_leaf   = a_q.node < NodeW'(cnt_q);
	assign b_leaf   = b_q.node < NodeW'(cnt_q);

	assign symbols.ready = (state_q == S_IDLE);
	assign merges.valid  = ov_q;
	assign merges.data   = out_q;

	always_comb begin
		h_we  = 1'b0;
		h_wa  = pos_q;
		h_wd  = cur_q;
		h_ra0 = s_q;
		h_ra1 = lc[SlotW-1:0];
		unique case (state_q)
			S_IDLE: begin
				h_we = acc && room;
				h_wa = cnt_q[SlotW-1:0];
				h_wd = {WeightW'(symbols.data.frequency), NodeW'(cnt_q)};
			end
			S_SDRD: begin
				h_ra0 = lc[SlotW-1:0];
				h_ra1 = rc[SlotW-1:0];
			end
			S_SDCMP: begin
				h_we = 1'b1;
				h_wa = pos_q;
				if (take_r) begin
					h_wd = hrd1_q;
				end else if (take_l) begin
					h_wd = hrd0_q;
				end else begin
					h_wd = cur_q;
				end
			end
			S_TRD: begin
				h_ra0 = '0;
				h_ra1 = SlotW'(hc_q - 1'b1);
			end
			S_URD: begin
				h_ra0 = parent;
				h_we  = (i_q == '0);
				h_wa  = i_q;
				h_wd  = {w_q, nn_q};
			end
			S_UCMP: begin
				h_we = 1'b1;
				h_wa = i_q;
				h_wd = (w_q < hrd0_q.w) ? hrd0_q : {w_q, nn_q};
			end
			default: begin
				h_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			heap_mem[h_wa] <= h_wd;
		end
		hrd0_q <= heap_mem[h_ra0];
		hrd1_q <= heap_mem[h_ra1];
		if (acc && room) begin
			sym_mem[cnt_q[SlotW-1:0]] <= symbols.data.symbol;
		end
		srd0_q <= sym_mem[a_q.node[SlotW-1:0]];
		srd1_q <= sym_mem[b_q.node[SlotW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_HEAP;
			cnt_q   <= '0;
			hc_q    <= '0;
			nxt_q   <= '0;
			drop_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (merges.valid && merges.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= cnt_new;
						if (!room) begin
							drop_q <= 1'b1;
						end
						a_q <= {WeightW'(symbols.data.frequency), NodeW'(cnt_q)};
						if (symbols.data.last) begin
							hc_q  <= cnt_new;
							nxt_q <= NodeW'(cnt_new);
							s_q   <= SlotW'((cnt_new - 2'd2) >> 1);
							ret_q <= RET_HEAP;
							state_q <= (cnt_new == CountW'(1)) ? S_SGL : S_HRD;
						end
					end
				end
				S_SGL: begin
					if (out_free) begin
						out_q <= '{node_index: a_q.node, left_index: '0, right_index: '0,
							left_is_leaf: 1'b0, right_is_leaf: 1'b0, left_symbol: '0,
							right_symbol: '0, weight: a_q.w, single_leaf: 1'b1,
							overflow: drop_q, is_root: 1'b1};
						cnt_q   <= '0;
						hc_q    <= '0;
						nxt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_HRD: begin
					state_q <= S_HLD;
				end
				S_HLD: begin
					cur_q   <= hrd0_q;
					pos_q   <= s_q;
					state_q <= S_SDRD;
				end
				S_SDRD: begin
					state_q <= S_SDCMP;
				end
				S_SDCMP: begin
					if (take_r) begin
						pos_q   <= rc[SlotW-1:0];
						state_q <= S_SDRD;
					end else if (take_l) begin
						pos_q   <= lc[SlotW-1:0];
						state_q <= S_SDRD;
					end else begin
						unique case (ret_q)
							RET_HEAP: begin
								if (s_q == '0) begin
									ret_q   <= RET_TAKE1;
									state_q <= S_TRD;
								end else begin
									s_q     <= s_q - 1'b1;
									state_q <= S_HRD;
								end
							end
							RET_TAKE1: begin
								ret_q   <= RET_TAKE2;
								state_q <= S_TRD;
							end
							default: begin
								state_q <= S_MG;
							end
						endcase
					end
				end
				S_TRD: begin
					state_q <= S_TLD;
				end
				S_TLD: begin
					if (ret_q == RET_TAKE1) begin
						a_q <= hrd0_q;
					end else begin
						b_q <= hrd0_q;
					end
					cur_q   <= hrd1_q;
					hc_q    <= hc_q - 1'b1;
					pos_q   <= '0;
					state_q <= S_SDRD;
				end
				S_MG: begin
					nn_q    <= nxt_q;
					nxt_q   <= nxt_q + 1'b1;
					w_q     <= a_q.w + b_q.w;
					i_q     <= SlotW'(hc_q);
					state_q <= S_URD;
				end
				S_URD: begin
					if (i_q == '0) begin
						hc_q    <= hc_q + 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_UCMP;
					end
				end
				S_UCMP: begin
					if (w_q < hrd0_q.w) begin
						i_q     <= parent;
						state_q <= S_URD;
					end else begin
						hc_q    <= hc_q + 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q <= '{node_index: nn_q, left_index: a_q.node,
							right_index: b_q.node, left_is_leaf: a_leaf,
							right_is_leaf: b_leaf, left_symbol: a_leaf ? srd0_q : '0,
							right_symbol: b_leaf ? srd1_q : '0, weight: w_q,
							single_leaf: 1'b0, overflow: drop_q,
							is_root: hc_q == CountW'(1)};
						if (hc_q == CountW'(1)) begin
							cnt_q   <= '0;
							hc_q    <= '0;
							nxt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							ret_q   <= RET_TAKE1;
							state_q <= S_TRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountW'(MaxSymbols) && hc_q <= CountW'(MaxSymbols))
		else $error("Symbol or heap count beyond capacity.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> cnt_q == CountW'(MaxSymbols))
		else $error("Overflow flagged while capacity remains.");

	a_sift_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SDCMP) |-> (CountW'(pos_q) < hc_q || hc_q == '0))
		else $error("Sift position outside the heap.");

	a_emit_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> hc_q != '0)
		else $error("Result emitted from an empty heap.");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && $past(state_q) == S_IDLE) |-> cnt_q != '0)
		else $error("Build started with no symbols.");

endmodule

FILE: tb/tb_huffman_tree_builder_unit.sv
module tb_huffman_tree_builder_unit;
	import htb_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int IdlePct    = 28;

	typedef struct {
		sym_beat_t   beat;
		bit          typed;
		merge_beat_t res;
	} table_row_t;

	logic clk;
	logic arst_n;

	htb_sym_if   sym_ch();
	htb_merge_if mrg_ch();

	huffman_tree_builder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.symbols (sym_ch),
		.merges  (mrg_ch)
	);

	logic [SymW-1:0]    leaf_sym [MaxSymbols];
	logic [WeightW-1:0] node_wt [NodeCap];
	logic [NodeW-1:0]   heap_slot [MaxSymbols];
	int                 loaded_n;
	int                 heap_n;
	bit                 dropped;

	merge_beat_t pending_merges[$];
	table_row_t  stim_rows[$];
	int          errors;
	int          cycles;
	int          beats_sent;
	int          sets_sent;
	int          merges_seen;
	bit          calm;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				pending_merges.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [WeightW-1:0] slot_wt(int s);
		return node_wt[heap_slot[s % MaxSymbols] % NodeCap];
	endfunction

	function automatic void sift_down(int p);
		int l;
		int r;
		int m;
		logic [NodeW-1:0] t;
		forever begin
			l = 2 * p + 1;
			r = 2 * p + 2;
			m = p;
			if (l < heap_n && slot_wt(l) < slot_wt(p))
				m = l;
			if (r < heap_n && slot_wt(r) < slot_wt(m))
				m = r;
			if (m == p)
				return;
			t = heap_slot[p];
			heap_slot[p] = heap_slot[m];
			heap_slot[m] = t;
			p = m;
		end
	endfunction

	function automatic int pop_min();
		int top;
		top = int'(heap_slot[0]);
		if (heap_n > 0)
			heap_n--;
		heap_slot[0] = heap_slot[heap_n % MaxSymbols];
		sift_down(0);
		return top;
	endfunction

	function automatic void push_node(int nd);
		int i;
		logic [WeightW-1:0] w;
		i = heap_n;
		w = node_wt[nd % NodeCap];
		while (i != 0 && w < slot_wt((i - 1) / 2)) begin
			heap_slot[i % MaxSymbols] = heap_slot[(i - 1) / 2];
			i = (i - 1) / 2;
		end
		heap_slot[i % MaxSymbols] = NodeW'(nd);
		heap_n++;
	endfunction

	// Loads one leaf and, on the final beat of a set, builds the tree and queues the merges.
	function automatic void predict_tree(sym_beat_t b, ref merge_beat_t res[$]);
		int n;
		int nxt;
		int a;
		int c;
		merge_beat_t r;
		res.delete();
		if (loaded_n < MaxSymbols) begin
			leaf_sym[loaded_n] = b.symbol;
			node_wt[loaded_n] = WeightW'(b.frequency);
			loaded_n++;
		end else begin
			dropped = 1'b1;
		end
		if (!b.last)
			return;
		for (int i = 0; i < loaded_n; i++)
			heap_slot[i] = NodeW'(i);
		heap_n = loaded_n;
		nxt = loaded_n;
		n = heap_n - 1;
		for (int s = (n - 1) / 2; s >= 0; s--)
			sift_down(s);
		if (heap_n == 1) begin
			r = '0;
			r.node_index = heap_slot[0];
			r.weight = node_wt[heap_slot[0]];
			r.single_leaf = 1'b1;
			r.overflow = dropped;
			r.is_root = 1'b1;
			res.push_back(r);
		end else begin
			while (heap_n > 1 && nxt < NodeCap) begin
				a = pop_min();
				c = pop_min();
				node_wt[nxt] = node_wt[a] + node_wt[c];
				push_node(nxt);
				r = '0;
				r.node_index = NodeW'(nxt);
				r.left_index = NodeW'(a);
				r.right_index = NodeW'(c);
				r.left_is_leaf = a < loaded_n;
				r.right_is_leaf = c < loaded_n;
				r.left_symbol = (a < loaded_n) ? leaf_sym[a] : '0;
				r.right_symbol = (c < loaded_n) ? leaf_sym[c] : '0;
				r.weight = node_wt[nxt];
				r.overflow = dropped;
				r.is_root = heap_n == 1;
				res.push_back(r);
				nxt++;
			end
		end
		loaded_n = 0;
		heap_n = 0;
		dropped = 1'b0;
	endfunction

	task automatic flag_field(string name, longint unsigned want, longint unsigned got);
		errors++;
		if (errors <= 10)
			$display("Mismatch in %s at cycle %0d: expected %0h, got %0h", name, cycles,
				want, got);
	endtask

	always @(posedge clk) begin
		merge_beat_t want;
		merge_beat_t got;
		if (mrg_ch.valid && mrg_ch.ready) begin
			got = mrg_ch.data;
			merges_seen++;
			if (pending_merges.size() == 0) begin
				flag_field("unexpected beat node_index", 0, got.node_index);
			end else begin
				want = pending_merges.pop_front();
				if (got.node_index !== want.node_index)
					flag_field("node_index", want.node_index, got.node_index);
				if (got.left_index !== want.left_index)
					flag_field("left_index", want.left_index, got.left_index);
				if (got.right_index !== want.right_index)
					flag_field("right_index", want.right_index, got.right_index);
				if (got.left_is_leaf !== want.left_is_leaf)
					flag_field("left_is_leaf", want.left_is_leaf, got.left_is_leaf);
				if (got.right_is_leaf !== want.right_is_leaf)
					flag_field("right_is_leaf", want.right_is_leaf, got.right_is_leaf);
				if (got.left_symbol !== want.left_symbol)
					flag_field("left_symbol", want.left_symbol, got.left_symbol);
				if (got.right_symbol !== want.right_symbol)
					flag_field("right_symbol", want.right_symbol, got.right_symbol);
				if (got.weight !== want.weight)
					flag_field("weight", want.weight, got.weight);
				if (got.single_leaf !== want.single_leaf)
					flag_field("single_leaf", want.single_leaf, got.single_leaf);
				if (got.overflow !== want.overflow)
					flag_field("overflow", want.overflow, got.overflow);
				if (got.is_root !== want.is_root)
					flag_field("is_root", want.is_root, got.is_root);
			end
		end
		if (arst_n)
			mrg_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
	end

	task automatic send_leaf(sym_beat_t b, bit typed, merge_beat_t typed_res);
		merge_beat_t res[$];
		while (!calm && $urandom_range(99) < IdlePct) begin
			sym_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sym_ch.valid <= 1'b1;
		sym_ch.data <= b;
		predict_tree(b, res);
		if (typed && b.last)
			pending_merges.push_back(typed_res);
		else
			foreach (res[i])
				pending_merges.push_back(res[i]);
		do
			@(posedge clk);
		while (!sym_ch.ready);
		beats_sent++;
		if (b.last)
			sets_sent++;
	endtask

	function automatic table_row_t row(logic [SymW-1:0] s, logic [FreqW-1:0] f, bit l);
		table_row_t t;
		t.beat = '{symbol: s, frequency: f, last: l};
		t.typed = 1'b0;
		t.res = '0;
		return t;
	endfunction

	initial begin
		table_row_t t;
		sym_beat_t b;
		int n;
		int mode;
		int rand_beats;
		calm = 1'b0;
		errors = 0;
		cycles = 0;
		beats_sent = 0;
		sets_sent = 0;
		merges_seen = 0;
		loaded_n = 0;
		heap_n = 0;
		dropped = 1'b0;
		arst_n = 1'b0;
		sym_ch.valid = 1'b0;
		sym_ch.data = '0;
		mrg_ch.ready = 1'b0;

		t = row(8'hA5, 24'h0, 1'b1);
		t.typed = 1'b1;
		t.res.single_leaf = 1'b1;
		t.res.is_root = 1'b1;
		stim_rows.push_back(t);
		t = row(8'hFF, 24'hFFFFFF, 1'b1);
		t.typed = 1'b1;
		t.res.weight = 30'hFFFFFF;
		t.res.single_leaf = 1'b1;
		t.res.is_root = 1'b1;
		stim_rows.push_back(t);
		stim_rows.push_back(row(8'h00, 24'd5, 1'b0));
		t = row(8'hFF, 24'd9, 1'b1);
		t.typed = 1'b1;
		t.res = '{node_index: 7'd2, left_index: 7'd0, right_index: 7'd1,
			left_is_leaf: 1'b1, right_is_leaf: 1'b1, left_symbol: 8'h00,
			right_symbol: 8'hFF, weight: 30'd14, single_leaf: 1'b0,
			overflow: 1'b0, is_root: 1'b1};
		stim_rows.push_back(t);
		stim_rows.push_back(row(8'h11, 24'd7, 1'b0));
		stim_rows.push_back(row(8'h22, 24'd7, 1'b1));
		stim_rows.push_back(row(8'h01, 24'hFFFFFF, 1'b0));
		stim_rows.push_back(row(8'h80, 24'd3, 1'b0));
		stim_rows.push_back(row(8'h7F, 24'd3, 1'b0));
		stim_rows.push_back(row(8'hFE, 24'h0, 1'b0));
		stim_rows.push_back(row(8'h55, 24'hFFFFFF, 1'b0));
		stim_rows.push_back(row(8'hAA, 24'd3, 1'b0));
		stim_rows.push_back(row(8'h0F, 24'h800000, 1'b0));
		stim_rows.push_back(row(8'hF0, 24'h0, 1'b1));
		for (int i = 0; i < 5; i++)
			stim_rows.push_back(row(SymW'(8'h30 + i), FreqW'(50 - 10 * i), i == 4));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_leaf(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].res);

		// Beats beyond capacity are dropped; the dropped final beat still starts the build.
		rand_beats = stim_rows.size();
		for (int i = 0; i < MaxSymbols + 2; i++) begin
			b.symbol = SymW'($urandom);
			b.frequency = FreqW'($urandom);
			b.last = i == MaxSymbols + 1;
			send_leaf(b, 1'b0, '0);
			rand_beats++;
		end

		while (rand_beats < 110 || sets_sent < 12) begin
			calm = (sets_sent % 9) == 8;
			if ($urandom_range(11) == 0)
				n = 1;
			else if ($urandom_range(15) == 0)
				n = $urandom_range(40, 20);
			else
				n = $urandom_range(10, 2);
			mode = $urandom_range(2);
			for (int i = 0; i < n; i++) begin
				b.symbol = SymW'($urandom);
				b.frequency = (mode == 0) ? FreqW'($urandom_range(3)) :
					(mode == 1) ? FreqW'($urandom) : FreqW'($urandom_range(255));
				b.last = i == n - 1;
				send_leaf(b, 1'b0, '0);
				rand_beats++;
			end
		end
		sym_ch.valid <= 1'b0;
		calm = 1'b0;

		while (pending_merges.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("Sent %0d symbol beats in %0d sets, including an overflowing set.",
			beats_sent, sets_sent);
		$display("Checked %0d merge beats; %0d mismatches found.", merges_seen, errors);
		if (errors == 0 && pending_merges.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
